/* rtl/cvlb_pkg.sv */
// Shared constants, types and helpers for the 3x3 line-buffer convolution filter.
package cvlb_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int COLS_W     = 11;
	localparam int ROWS_W     = 16;
	localparam int PIX_W      = 8;
	localparam int KROW_W     = 24;
	localparam int NUM_BANKS  = 3;
	localparam int KSIZE      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	// Width for comparing the column counter with the clamped line width.
	localparam int LIM_W      = (COL_W + 1 > COLS_W) ? COL_W + 1 : COLS_W;

	localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(128);
	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(128);

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [1:0]        bank_t;
	typedef logic [KROW_W-1:0] krow_t;

	localparam bank_t BANK_RESET = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KROW0 = 3'd0,
		CFG_KROW1 = 3'd1,
		CFG_KROW2 = 3'd2,
		CFG_COLS  = 3'd3,
		CFG_ROWS  = 3'd4
	} cfg_idx_t;

	// Control that travels with a pixel from the line store stage to the window.
	typedef struct packed {
		logic valid;
		logic upd;
		logic emit;
		logic last;
	} ctl_s1_t;

	// Store line that feeds a window row, given the line that takes the current row.
	// The bottom row always comes from the current line itself.
	function automatic bank_t pick_line(input bank_t newest, input logic mid_row);
		bank_t res;
		case (newest)
			2'd0: res = mid_row ? 2'd2 : 2'd1;
			2'd1: res = mid_row ? 2'd0 : 2'd2;
			default: res = mid_row ? 2'd1 : 2'd0;
		endcase
		return res;
	endfunction

endpackage

/* rtl/conv3x3_line_buffer_filter.sv */
// Top level of the 3x3 convolution filter over a raster pixel stream.
//
// Pixels arrive one per transaction in raster order for a frame of image_cols by
// image_rows. The block accepts one pixel every clock while the output side
// keeps up; throughput is one pixel per cycle, set by the single write and
// single read port of each of the three line-store banks, which are all touched
// once per pixel. After its pixel is accepted, a result passes through the
// line-store read, window shift, the nine coefficient products, then the sum in
// the output register. Rows 0 and 1 and columns 0 and 1 of every row give no
// result; frame_end marks the last result of a frame. pixel_out is the low byte
// of the weighted sum. Coefficients are unsigned bytes, column 0 in the low byte
// of each kernel row. Write the configuration registers only while the stream is
// idle; cfg_ready is always high. The line store is not cleared at reset, so
// changing the geometry in the middle of a frame can yield stale window data.
module conv3x3_line_buffer_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cvlb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cvlb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      pixel_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      pixel_out,
	output logic                            frame_end
);

	cvlb_pkg::krow_t             kernel_q [cvlb_pkg::KSIZE];
	logic [cvlb_pkg::COLS_W-1:0] image_cols_q;
	logic [cvlb_pkg::ROWS_W-1:0] image_rows_q;

	logic                        advance;
	logic                        accept;
	cvlb_pkg::ctl_s1_t           ctl_s1;
	cvlb_pkg::pix_t              top_s1;
	cvlb_pkg::pix_t              mid_s1;
	cvlb_pkg::pix_t              bot_s1;

	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q[0]  <= '0;
			kernel_q[1]  <= '0;
			kernel_q[2]  <= '0;
			image_cols_q <= cvlb_pkg::COLS_RESET;
			image_rows_q <= cvlb_pkg::ROWS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cvlb_pkg::cfg_idx_t'(cfg_index))
				cvlb_pkg::CFG_KROW0: kernel_q[0] <= cfg_data[cvlb_pkg::KROW_W-1:0];
				cvlb_pkg::CFG_KROW1: kernel_q[1] <= cfg_data[cvlb_pkg::KROW_W-1:0];
				cvlb_pkg::CFG_KROW2: kernel_q[2] <= cfg_data[cvlb_pkg::KROW_W-1:0];
				cvlb_pkg::CFG_COLS:  image_cols_q <= cfg_data[cvlb_pkg::COLS_W-1:0];
				cvlb_pkg::CFG_ROWS:  image_rows_q <= cfg_data[cvlb_pkg::ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless a finished result is held by the sink;
	// bubbles in the stages are not filled while it is held, and no pixel is taken.
	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	cvlb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.advance    (advance),
		.pixel      (pixel_in),
		.image_cols (image_cols_q),
		.image_rows (image_rows_q),
		.ctl_s1     (ctl_s1),
		.top_s1     (top_s1),
		.mid_s1     (mid_s1),
		.bot_s1     (bot_s1)
	);

	cvlb_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.top_s1    (top_s1),
		.mid_s1    (mid_s1),
		.bot_s1    (bot_s1),
		.kernel    (kernel_q),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.pixel_out (pixel_out),
		.frame_end (frame_end)
	);

endmodule

/* rtl/cvlb_ram.sv */
// Generic simple dual-port RAM with registered read.
module cvlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/cvlb_ctrl.sv */
// Raster counters, three-line store and the column fetch stage.
module cvlb_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          advance,
	input  cvlb_pkg::pix_t                pixel,
	input  logic [cvlb_pkg::COLS_W-1:0]   image_cols,
	input  logic [cvlb_pkg::ROWS_W-1:0]   image_rows,
	output cvlb_pkg::ctl_s1_t             ctl_s1,
	output cvlb_pkg::pix_t                top_s1,
	output cvlb_pkg::pix_t                mid_s1,
	output cvlb_pkg::pix_t                bot_s1
);

	logic [cvlb_pkg::COL_W-1:0]  col_q;
	logic [cvlb_pkg::ROWS_W-1:0] row_q;
	cvlb_pkg::bank_t             newest_q;

	logic [cvlb_pkg::LIM_W-1:0]  cols_ext;
	logic [cvlb_pkg::LIM_W-1:0]  cols_lim;
	logic [cvlb_pkg::ROWS_W-1:0] rows_lim;
	logic                        line_end;
	logic                        frame_last;
	logic                        row_ge2;
	logic                        emit;
	cvlb_pkg::bank_t             wr_bank;
	cvlb_pkg::bank_t             newest_rot;

	logic                        valid_s1;
	logic                        upd_s1;
	logic                        emit_s1;
	logic                        last_s1;
	cvlb_pkg::bank_t             newest_s1;
	cvlb_pkg::pix_t              pix_s1;
	cvlb_pkg::pix_t              rd_data [cvlb_pkg::NUM_BANKS];

	always_comb begin
		cols_ext = cvlb_pkg::LIM_W'(image_cols);
		if (image_cols == '0) begin
			cols_lim = cvlb_pkg::LIM_W'(1);
		end else if (cols_ext > cvlb_pkg::LIM_W'(cvlb_pkg::MAX_COLS)) begin
			cols_lim = cvlb_pkg::LIM_W'(cvlb_pkg::MAX_COLS);
		end else begin
			cols_lim = cols_ext;
		end
		rows_lim   = (image_rows == '0) ? cvlb_pkg::ROWS_W'(1) : image_rows;
		line_end   = cvlb_pkg::LIM_W'(col_q) >= (cols_lim - cvlb_pkg::LIM_W'(1));
		frame_last = line_end && (row_q >= (rows_lim - cvlb_pkg::ROWS_W'(1)));
		row_ge2    = (row_q[cvlb_pkg::ROWS_W-1:1] != '0);
		emit       = row_ge2 && (col_q >= cvlb_pkg::COL_W'(2));
		wr_bank    = row_ge2 ? newest_q : {1'b0, row_q[0]};
		newest_rot = (newest_q == 2'd2) ? 2'd0 : newest_q + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			newest_q <= cvlb_pkg::BANK_RESET;
		end else if (accept) begin
			if (frame_last) begin
				col_q    <= '0;
				row_q    <= '0;
				newest_q <= cvlb_pkg::BANK_RESET;
			end else if (line_end) begin
				col_q <= '0;
				row_q <= row_q + cvlb_pkg::ROWS_W'(1);
				if (row_ge2) begin
					newest_q <= newest_rot;
				end
			end else begin
				col_q <= col_q + cvlb_pkg::COL_W'(1);
			end
		end
	end

	for (genvar b = 0; b < cvlb_pkg::NUM_BANKS; b++) begin : g_bank
		cvlb_ram #(
			.WIDTH (cvlb_pkg::PIX_W),
			.DEPTH (cvlb_pkg::MAX_COLS)
		) u_line (
			.clk     (clk),
			.wr_en   (accept && (wr_bank == cvlb_pkg::bank_t'(b))),
			.wr_addr (col_q),
			.wr_data (pixel),
			.rd_en   (accept),
			.rd_addr (col_q),
			.rd_data (rd_data[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= pixel;
			newest_s1 <= newest_q;
			upd_s1    <= row_ge2;
			emit_s1   <= emit;
			last_s1   <= frame_last;
		end
	end

	assign ctl_s1 = '{valid: valid_s1, upd: upd_s1, emit: emit_s1, last: last_s1};
	assign top_s1 = rd_data[cvlb_pkg::pick_line(newest_s1, 1'b0)];
	assign mid_s1 = rd_data[cvlb_pkg::pick_line(newest_s1, 1'b1)];
	assign bot_s1 = pix_s1;

endmodule

/* rtl/cvlb_mac.sv */
// Sliding 3x3 window, coefficient products, sum and the result register.
module cvlb_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  cvlb_pkg::ctl_s1_t ctl_s1,
	input  cvlb_pkg::pix_t    top_s1,
	input  cvlb_pkg::pix_t    mid_s1,
	input  cvlb_pkg::pix_t    bot_s1,
	input  cvlb_pkg::krow_t   kernel [cvlb_pkg::KSIZE],
	input  logic              out_stall,
	output logic              advance,
	output logic              out_valid,
	output cvlb_pkg::pix_t    pixel_out,
	output logic              frame_end
);

	cvlb_pkg::pix_t              win_q   [cvlb_pkg::KSIZE][cvlb_pkg::KSIZE];
	cvlb_pkg::pix_t              new_col [cvlb_pkg::KSIZE];
	logic [2*cvlb_pkg::PIX_W-1:0] prod   [cvlb_pkg::KSIZE][cvlb_pkg::KSIZE];
	cvlb_pkg::pix_t              prod_s3 [cvlb_pkg::KSIZE][cvlb_pkg::KSIZE];
	cvlb_pkg::pix_t              row_sum [cvlb_pkg::KSIZE];
	cvlb_pkg::pix_t              total;

	logic                        valid_s2;
	logic                        last_s2;
	logic                        valid_s3;
	logic                        last_s3;
	logic                        out_valid_q;
	cvlb_pkg::pix_t              pixel_out_q;
	logic                        frame_end_q;

	assign advance    = !(out_valid_q && out_stall);
	assign new_col[0] = top_s1;
	assign new_col[1] = mid_s1;
	assign new_col[2] = bot_s1;

	// Shift the window left and take the fetched column on the right.
	always_ff @(posedge clk) begin
		if (advance && ctl_s1.valid && ctl_s1.upd) begin
			for (int r = 0; r < cvlb_pkg::KSIZE; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= new_col[r];
			end
		end
	end

	always_comb begin
		for (int r = 0; r < cvlb_pkg::KSIZE; r++) begin
			for (int c = 0; c < cvlb_pkg::KSIZE; c++) begin
				prod[r][c] = (2*cvlb_pkg::PIX_W)'(win_q[r][c])
					* (2*cvlb_pkg::PIX_W)'(kernel[r][c*cvlb_pkg::PIX_W +: cvlb_pkg::PIX_W]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			for (int r = 0; r < cvlb_pkg::KSIZE; r++) begin
				for (int c = 0; c < cvlb_pkg::KSIZE; c++) begin
					prod_s3[r][c] <= prod[r][c][cvlb_pkg::PIX_W-1:0];
				end
			end
		end
	end

	// Only the low byte survives, so the whole tree wraps at 8 bits.
	always_comb begin
		for (int r = 0; r < cvlb_pkg::KSIZE; r++) begin
			row_sum[r] = prod_s3[r][0] + prod_s3[r][1] + prod_s3[r][2];
		end
		total = row_sum[0] + row_sum[1] + row_sum[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s2    <= ctl_s1.valid && ctl_s1.emit;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s2 <= ctl_s1.last;
			last_s3 <= last_s2;
			if (valid_s3) begin
				pixel_out_q <= total;
				frame_end_q <= last_s3;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the 3x3 line-buffer convolution filter.
module tb_top;

	// Run limits.
	localparam int CYCLE_LIMIT   = 100000;
	localparam int DRAIN_LIMIT   = 20000;
	// Let the pipeline empty before touching registers.
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_PIXELS  = 40;

	// Register indexes the block does not decode; writes there must be ignored.
	localparam logic [cvlb_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [cvlb_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// Store line feeding window rows top, middle, bottom, per line taking the current row.
	localparam int LINE_PICK [3][3] = '{'{1, 2, 0}, '{2, 0, 1}, '{0, 1, 2}};

	typedef struct {
		cvlb_pkg::pix_t value;
		logic           last;
	} conv_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [cvlb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cvlb_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	cvlb_pkg::pix_t                  pixel_in;
	logic                            out_valid;
	logic                            out_stall;
	cvlb_pkg::pix_t                  pixel_out;
	logic                            frame_end;

	// Predictor state: registers, line store, window and raster position.
	cvlb_pkg::krow_t             kernel [3];
	logic [cvlb_pkg::COLS_W-1:0] line_width;
	logic [cvlb_pkg::ROWS_W-1:0] frame_height;
	cvlb_pkg::pix_t              line_mem [cvlb_pkg::NUM_BANKS * cvlb_pkg::MAX_COLS];
	cvlb_pkg::pix_t              win [3][3];
	int unsigned                 col_pos;
	int unsigned                 row_pos;
	int unsigned                 fill_line;

	conv_result_t conv_results_due [$];
	conv_result_t oldest_due;

	int          send_idle_pct;
	int          out_stall_pct;
	int unsigned pixels_sent;
	int unsigned results_checked;
	int unsigned frames_done;
	int unsigned error_count;
	int unsigned cycle_count;

	conv3x3_line_buffer_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.frame_end (frame_end)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, conv_results_due.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	// Downstream back-pressure, redrawn every cycle at the falling edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	// Compare every output transaction with the oldest predicted result.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (conv_results_due.size() == 0) begin
				$error("unexpected result: pixel_out %0d frame_end %0b", pixel_out, frame_end);
				error_count++;
			end else begin
				oldest_due = conv_results_due.pop_front();
				results_checked++;
				if (pixel_out !== oldest_due.value) begin
					$error("pixel_out: expected %0d, got %0d", oldest_due.value, pixel_out);
					error_count++;
				end
				if (frame_end !== oldest_due.last) begin
					$error("frame_end: expected %0b, got %0b", oldest_due.last, frame_end);
					error_count++;
				end
			end
		end
	end

	// Put the predictor in its post-reset state. Unwritten store entries read as zero,
	// though the stimulus never reads one.
	task automatic reset_predictor();
		for (int r = 0; r < 3; r++) begin
			kernel[r] = '0;
			for (int c = 0; c < 3; c++) begin
				win[r][c] = '0;
			end
		end
		foreach (line_mem[i]) begin
			line_mem[i] = '0;
		end
		line_width   = cvlb_pkg::COLS_RESET;
		frame_height = cvlb_pkg::ROWS_RESET;
		col_pos      = 0;
		row_pos      = 0;
		fill_line    = cvlb_pkg::BANK_RESET;
	endtask

	// Advance the predictor by one accepted pixel and queue the result it causes, if any.
	function automatic void convolve_pixel(input cvlb_pkg::pix_t p);
		int unsigned  width;
		int unsigned  height;
		int unsigned  col;
		int unsigned  lb;
		int unsigned  acc;
		bit           line_end;
		bit           frame_last;
		conv_result_t res;

		// Clamp the geometry the way the block does: zero means one, width saturates.
		width = (line_width == 0) ? 1 : line_width;
		if (width > cvlb_pkg::MAX_COLS) begin
			width = cvlb_pkg::MAX_COLS;
		end
		height = (frame_height == 0) ? 1 : frame_height;
		col = (col_pos >= cvlb_pkg::MAX_COLS) ? cvlb_pkg::MAX_COLS - 1 : col_pos;
		lb = (fill_line > 2) ? 2 : fill_line;

		// Compare with >= so that a geometry cut mid-frame ends the line or frame at once.
		line_end   = (col_pos >= width - 1);
		frame_last = line_end && (row_pos >= height - 1);

		if (row_pos < 2) begin
			line_mem[row_pos * cvlb_pkg::MAX_COLS + col] = p;
		end else begin
			line_mem[lb * cvlb_pkg::MAX_COLS + col] = p;
			for (int r = 0; r < 3; r++) begin
				if (col > 2) begin
					win[r][0] = win[r][1];
					win[r][1] = win[r][2];
					win[r][2] = line_mem[LINE_PICK[lb][r] * cvlb_pkg::MAX_COLS + col];
				end else begin
					win[r][col] = line_mem[LINE_PICK[lb][r] * cvlb_pkg::MAX_COLS + col];
				end
			end
			if (col >= 2) begin
				acc = 0;
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						acc += int'(win[r][c]) * int'(kernel[r][8 * c +: 8]);
					end
				end
				res.value = acc[7:0];
				res.last  = frame_last;
				conv_results_due.push_back(res);
			end
			// Rotate the store at every line end from row 2 on, width 3 included.
			if (line_end) begin
				lb = (lb == 2) ? 0 : lb + 1;
			end
		end

		if (frame_last) begin
			col_pos   = 0;
			row_pos   = 0;
			fill_line = cvlb_pkg::BANK_RESET;
			frames_done++;
		end else if (line_end) begin
			col_pos   = 0;
			row_pos   = (row_pos + 1) & 32'hFFFF;
			fill_line = lb;
		end else begin
			col_pos   = col + 1;
			fill_line = lb;
		end
	endfunction

	// Pick a pixel, favoring the two extremes.
	function automatic cvlb_pkg::pix_t rand_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return cvlb_pkg::pix_t'($urandom);
		endcase
	endfunction

	// Pick a kernel row, now and then all-zero or all-ones.
	function automatic cvlb_pkg::krow_t rand_krow();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return cvlb_pkg::krow_t'($urandom);
		endcase
	endfunction

	// Offer one pixel and hold it until the block takes it. Called and returns at a
	// falling edge; valid stays high for the next pixel unless an idle cycle drops it.
	task automatic send_pixel(input cvlb_pkg::pix_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			pixel_in <= cvlb_pkg::pix_t'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= p;
		do @(posedge clk); while (in_stall);
		convolve_pixel(p);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Send pixels up to and including the end of the current line.
	task automatic send_line();
		do send_pixel(rand_pixel()); while (col_pos != 0);
	endtask

	// Send pixels until the frame wraps; fill < 0 means random content.
	task automatic send_frame(input int fill);
		do begin
			send_pixel((fill < 0) ? rand_pixel() : cvlb_pkg::pix_t'(fill));
		end while (col_pos != 0 || row_pos != 0);
	endtask

	// Drop valid, wait for every predicted result, then let the pipeline empty.
	task automatic drain_results();
		int waited;

		waited = 0;
		in_valid <= 1'b0;
		while (conv_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (conv_results_due.size() != 0) begin
			$error("%0d expected results never arrived", conv_results_due.size());
			error_count += conv_results_due.size();
			conv_results_due.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write transaction; the predictor takes the value when it lands.
	task automatic write_reg(input logic [cvlb_pkg::CFG_IDX_W-1:0] idx,
		input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= cvlb_pkg::CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			cvlb_pkg::CFG_KROW0: kernel[0] = cvlb_pkg::krow_t'(value);
			cvlb_pkg::CFG_KROW1: kernel[1] = cvlb_pkg::krow_t'(value);
			cvlb_pkg::CFG_KROW2: kernel[2] = cvlb_pkg::krow_t'(value);
			cvlb_pkg::CFG_COLS:  line_width = cvlb_pkg::COLS_W'(value);
			cvlb_pkg::CFG_ROWS:  frame_height = cvlb_pkg::ROWS_W'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_kernel(input cvlb_pkg::krow_t k0, input cvlb_pkg::krow_t k1,
		input cvlb_pkg::krow_t k2);
		drain_results();
		write_reg(cvlb_pkg::CFG_KROW0, k0);
		write_reg(cvlb_pkg::CFG_KROW1, k1);
		write_reg(cvlb_pkg::CFG_KROW2, k2);
	endtask

	// Write the frame size; half the time put junk above the register width.
	task automatic set_geometry(input int unsigned cols, input int unsigned rows);
		drain_results();
		write_reg(cvlb_pkg::CFG_COLS,
			cols | ($urandom_range(1) ? ($urandom << cvlb_pkg::COLS_W) : 0));
		write_reg(cvlb_pkg::CFG_ROWS,
			rows | ($urandom_range(1) ? ($urandom << cvlb_pkg::ROWS_W) : 0));
	endtask

	// Reset geometry is 128 by 128 with a zero kernel, so two full lines fill the store
	// and the first result of the third line is zero with no frame end. Then load a
	// kernel and cut the line to four pixels and the frame to three rows: the next
	// pixel has to close the frame.
	task automatic test_reset_values();
		send_idle_pct = 0;
		out_stall_pct = 0;
		repeat (2) send_line();
		repeat (3) send_pixel(rand_pixel());
		set_kernel(rand_krow(), rand_krow(), rand_krow());
		write_reg(cvlb_pkg::CFG_COLS, 4);
		write_reg(cvlb_pkg::CFG_ROWS, 3);
		send_line();
	endtask

	// Frames too small to give a result, then the smallest frame that gives one with
	// every pixel and coefficient at full scale, then a width-3 frame over several
	// rows to walk the store rotation.
	task automatic test_narrow_frames();
		set_kernel('1, '1, '1);
		set_geometry(0, 0);
		send_frame(-1);
		set_geometry(2, 3);
		send_frame(-1);
		set_geometry(3, 2);
		send_frame(-1);
		set_geometry(3, 3);
		send_frame(255);
		set_kernel(rand_krow(), rand_krow(), rand_krow());
		set_geometry(3, 6);
		send_frame(-1);
	endtask

	// Writes to undecoded indexes must leave every register alone.
	task automatic test_spare_registers();
		set_kernel(rand_krow(), rand_krow(), rand_krow());
		set_geometry(5, 3);
		write_reg(CFG_SPARE_LO, $urandom);
		write_reg(CFG_SPARE_HI, $urandom);
		send_frame(-1);
	endtask

	// Random small frames under one idle mix. A quarter of the frames are broken off
	// at a line boundary: rows cut short, width narrowed, or kernel swapped mid-frame.
	// Width only ever shrinks mid-frame so no unwritten store entry is read.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int unsigned first_pixel;

		drain_results();
		send_idle_pct = idle_pct;
		out_stall_pct = stall_pct;
		first_pixel = pixels_sent;
		while (pixels_sent - first_pixel < PHASE_PIXELS) begin
			set_kernel(rand_krow(), rand_krow(), rand_krow());
			set_geometry($urandom_range(3, 12), $urandom_range(3, 6));
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 2)) send_line();
				drain_results();
				case ($urandom_range(2))
					0: write_reg(cvlb_pkg::CFG_ROWS, $urandom_range(0, row_pos + 1));
					1: write_reg(cvlb_pkg::CFG_COLS, $urandom_range(3, line_width));
					default: write_reg(cvlb_pkg::CFG_KROW1, rand_krow());
				endcase
			end
			send_frame(-1);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = cvlb_pkg::CFG_KROW0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		pixel_in        = '0;
		send_idle_pct   = 0;
		out_stall_pct   = 0;
		pixels_sent     = 0;
		results_checked = 0;
		frames_done     = 0;
		error_count     = 0;
		cycle_count     = 0;
		reset_predictor();

		// Hold reset, then release it away from the sampling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_narrow_frames();
		test_spare_registers();
		test_random_traffic(0, 0);
		test_random_traffic(74, 0);
		test_random_traffic(0, 74);
		test_random_traffic(21, 21);

		drain_results();
		$display("%0d pixels in, %0d results checked, %0d frames closed",
			pixels_sent, results_checked, frames_done);
		$display("reset geometry, frames from 1x1 to 12 wide, mid-frame cuts, four idle mixes");
		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
